FILE: sv/hmvn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmvn_pkg
// Shared types and constants for the height-grid mesh vertex generator.
// ----------------------------------------------------------------------------
package hmvn_pkg;

  localparam int HGT_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;
  localparam int DIM_W      = 13;
  localparam int SMOOTH_W   = 15;
  localparam int IDX_W      = 24;
  localparam int POS_W      = 14;
  localparam int NRM_W      = 16;
  localparam int NRMY_W     = 15;
  localparam int ROW_W      = 12;
  localparam int MAG_W      = 16;
  localparam int SQ_W       = 32;
  localparam int LEN2_W     = 34;
  localparam int QUO_W      = 31;
  localparam int ROOT_W     = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_SMOOTHING = 2'd2;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_FLUSH  = 1'b1;

  localparam logic [NRMY_W-1:0]   Q_ONE        = 15'd16384;
  localparam logic [DIM_W-1:0]    ROW_CAP      = 13'd4096;
  localparam logic [DIM_W-1:0]    GW_RESET     = 13'd1;
  localparam logic [DIM_W-1:0]    GH_RESET     = 13'd1;
  localparam logic [SMOOTH_W-1:0] SMOOTH_RESET = 15'd256;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_WR,
    ST_SQ,
    ST_NORM_GO,
    ST_NORM_WAIT,
    ST_OUT
  } hmvn_state_t;

  typedef enum logic [1:0] {
    NU_IDLE,
    NU_SQ,
    NU_DIV,
    NU_SQRT
  } hmvn_nu_state_t;

  typedef struct packed {
    logic take;
    logic rd_b;
    logic wr;
    logic sq;
    logic norm_go;
    logic load_out;
  } hmvn_cmd_t;

  typedef struct packed {
    logic emit;
    logic sq_done;
    logic norm_done;
    logic comp_last;
    logic out_busy;
  } hmvn_sts_t;

endpackage

FILE: sv/hmvn_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmvn_in_if / hmvn_out_if
// Valid/ready channels for height samples and mesh vertices.
// ----------------------------------------------------------------------------
interface hmvn_in_if import hmvn_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic signed [HGT_W-1:0] height;

  modport source (output valid, kind, height, input ready);
  modport sink (input valid, kind, height, output ready);
endinterface

interface hmvn_out_if import hmvn_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        vertex_index;
  logic signed [POS_W-1:0] pos_x_half;
  logic signed [POS_W-1:0] pos_z_half;
  logic signed [HGT_W-1:0] vertex_height;
  logic signed [NRM_W-1:0] normal_x;
  logic [NRMY_W-1:0]       normal_y;
  logic signed [NRM_W-1:0] normal_z;
  logic                    quad_valid;
  logic                    mesh_done;

  modport source (output valid, vertex_index, pos_x_half, pos_z_half, vertex_height,
                  normal_x, normal_y, normal_z, quad_valid, mesh_done, input ready);
  modport sink (input valid, vertex_index, pos_x_half, pos_z_half, vertex_height,
                normal_x, normal_y, normal_z, quad_valid, mesh_done, output ready);
endinterface

FILE: sv/hmvn_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmvn_norm
// One normal component: round(mag * 2^14 / sqrt(den)) by long division of
// mag^2 * 2^30 by den, then a digit-by-digit square root.
// ----------------------------------------------------------------------------
module hmvn_norm import hmvn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [MAG_W-1:0]  mag,
  input  logic [LEN2_W-1:0] den,
  output logic              done,
  output logic [NRMY_W-1:0] mid
);

  hmvn_nu_state_t      st_r, st_nxt;
  logic [4:0]          cnt_r;
  logic [MAG_W-1:0]    mag_r;
  logic [LEN2_W:0]     rem_r;
  logic [QUO_W-1:0]    quo_r;
  logic [31:0]         rad_r;
  logic [17:0]         sqrem_r;
  logic [ROOT_W-1:0]   root_r;
  logic                done_r;
  logic [NRMY_W-1:0]   mid_r;

  logic [LEN2_W:0]     trial_div;
  logic                div_ge;
  logic [QUO_W-1:0]    quo_nxt;
  logic [19:0]         sr;
  logic [19:0]         trial_sq;
  logic                sq_ge;
  logic [ROOT_W-1:0]   root_nxt;
  logic [16:0]         root_p1;

  assign trial_div = (cnt_r == 5'd0) ? rem_r : {rem_r[LEN2_W-1:0], 1'b0};
  assign div_ge    = trial_div >= {1'b0, den};
  assign quo_nxt   = {quo_r[QUO_W-2:0], div_ge};

  assign sr        = {sqrem_r, rad_r[31:30]};
  assign trial_sq  = {2'b00, root_r, 2'b01};
  assign sq_ge     = sr >= trial_sq;
  assign root_nxt  = {root_r[ROOT_W-2:0], sq_ge};
  assign root_p1   = {1'b0, root_nxt} + 17'd1;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      NU_IDLE: if (start) st_nxt = NU_SQ;
      NU_SQ:   st_nxt = NU_DIV;
      NU_DIV:  if (cnt_r == 5'd30) st_nxt = NU_SQRT;
      NU_SQRT: if (cnt_r == 5'd15) st_nxt = NU_IDLE;
      default: st_nxt = NU_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= NU_IDLE;
      cnt_r  <= 5'd0;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= 1'b0;
      case (st_r)
        NU_SQ:   cnt_r <= 5'd0;
        NU_DIV:  cnt_r <= (cnt_r == 5'd30) ? 5'd0 : cnt_r + 5'd1;
        NU_SQRT: begin
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd15) done_r <= 1'b1;
        end
        default: cnt_r <= 5'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      NU_IDLE: if (start) mag_r <= mag;
      NU_SQ: begin
        rem_r <= (LEN2_W+1)'(mag_r * mag_r);
        quo_r <= '0;
      end
      NU_DIV: begin
        rem_r <= div_ge ? trial_div - {1'b0, den} : trial_div;
        quo_r <= quo_nxt;
        if (cnt_r == 5'd30) begin
          rad_r   <= {1'b0, quo_nxt};
          sqrem_r <= '0;
          root_r  <= '0;
        end
      end
      NU_SQRT: begin
        sqrem_r <= 18'(sq_ge ? sr - trial_sq : sr);
        root_r  <= root_nxt;
        rad_r   <= {rad_r[29:0], 2'b00};
        // nearest odd 2*mid-1 not above the root
        if (cnt_r == 5'd15) mid_r <= NRMY_W'(root_p1 >> 1);
      end
      default: ;
    endcase
  end

  assign done = done_r;
  assign mid  = mid_r;

endmodule

FILE: sv/hmvn_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmvn_ctrl
// Sequencer: accept, line-store reads, write-back, squaring, normalising, output.
// ----------------------------------------------------------------------------
module hmvn_ctrl import hmvn_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  hmvn_sts_t sts,
  output hmvn_cmd_t cmd
);

  hmvn_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (sts.emit) state_nxt = ST_RD_A;
        end
      end
      ST_RD_A: state_nxt = ST_RD_B;
      ST_RD_B: begin
        cmd.rd_b  = 1'b1;
        state_nxt = ST_WR;
      end
      ST_WR: begin
        cmd.wr    = 1'b1;
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        cmd.sq = 1'b1;
        if (sts.sq_done) state_nxt = ST_NORM_GO;
      end
      ST_NORM_GO: begin
        cmd.norm_go = 1'b1;
        state_nxt   = ST_NORM_WAIT;
      end
      ST_NORM_WAIT: begin
        if (sts.norm_done) state_nxt = sts.comp_last ? ST_OUT : ST_NORM_GO;
      end
      ST_OUT: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

FILE: sv/hmvn_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmvn_dp
// Datapath: configuration, raster counters, two line stores, neighbour
// differences, squared length, normaliser and output register.
// ----------------------------------------------------------------------------
module hmvn_dp import hmvn_pkg::*; #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_idx,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                    in_kind,
  input  logic signed [HGT_W-1:0] in_height,
  input  hmvn_cmd_t               cmd,
  output hmvn_sts_t               sts,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic [IDX_W-1:0]        out_vertex_index,
  output logic signed [POS_W-1:0] out_pos_x_half,
  output logic signed [POS_W-1:0] out_pos_z_half,
  output logic signed [HGT_W-1:0] out_vertex_height,
  output logic signed [NRM_W-1:0] out_normal_x,
  output logic [NRMY_W-1:0]       out_normal_y,
  output logic signed [NRM_W-1:0] out_normal_z,
  output logic                    out_quad_valid,
  output logic                    out_mesh_done
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int CW1  = CW + 1;
  localparam int WCAP = (MAX_WIDTH > 8191) ? 8191 : MAX_WIDTH;
  localparam logic [DIM_W-1:0] WCAP_D = DIM_W'(WCAP);

  // configuration
  logic [DIM_W-1:0]    gw_r, gh_r;
  logic [SMOOTH_W-1:0] sm_r;
  logic [DIM_W-1:0]    eff_w, eff_h;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r <= GW_RESET;
      gh_r <= GH_RESET;
      sm_r <= SMOOTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_GRID_WIDTH:       gw_r <= cfg_wdata[DIM_W-1:0];
        CFG_GRID_HEIGHT:      gh_r <= cfg_wdata[DIM_W-1:0];
        CFG_NORMAL_SMOOTHING: sm_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (gw_r == '0)         eff_w = DIM_W'(1);
    else if (gw_r > WCAP_D) eff_w = WCAP_D;
    else                    eff_w = gw_r;
    if (gh_r == '0)          eff_h = DIM_W'(1);
    else if (gh_r > ROW_CAP) eff_h = ROW_CAP;
    else                     eff_h = gh_r;
  end

  // raster position and accept decision
  logic [CW-1:0]    col_r;
  logic [DIM_W-1:0] row_cnt_r;
  logic             flushing_r;
  logic [CW:0]      col_p1;
  logic             last_col;
  logic             is_sample, drop_s, do_store, do_emit_s, do_flush;

  assign col_p1    = {1'b0, col_r} + CW1'(1);
  assign last_col  = 15'(col_p1) >= 15'(eff_w);
  assign is_sample = (in_kind == KIND_SAMPLE);
  assign drop_s    = flushing_r || (row_cnt_r >= eff_h);
  assign do_store  = is_sample && !drop_s && (row_cnt_r == '0);
  assign do_emit_s = is_sample && !drop_s && (row_cnt_r != '0);
  assign do_flush  = (in_kind == KIND_FLUSH) && !(row_cnt_r < eff_h);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_cnt_r  <= '0;
      flushing_r <= 1'b0;
    end else if (cmd.take) begin
      if (do_store || do_emit_s) begin
        if (last_col) begin
          col_r     <= '0;
          row_cnt_r <= row_cnt_r + DIM_W'(1);
        end else begin
          col_r <= col_p1[CW-1:0];
        end
      end else if (do_flush) begin
        if (last_col) begin
          col_r      <= '0;
          row_cnt_r  <= '0;
          flushing_r <= 1'b0;
        end else begin
          col_r      <= col_p1[CW-1:0];
          flushing_r <= 1'b1;
        end
      end
    end
  end

  // latched item context
  logic [CW-1:0]           c_r;
  logic [ROW_W-1:0]        row_r;
  logic                    flush_r;
  logic signed [HGT_W-1:0] bottom_r;
  logic                    done_r;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      c_r      <= col_r;
      row_r    <= ROW_W'(row_cnt_r - DIM_W'(1));
      flush_r  <= (in_kind == KIND_FLUSH);
      bottom_r <= in_height;
      done_r   <= do_flush && last_col;
    end
  end

  // line stores
  logic signed [HGT_W-1:0] ctr_mem [MAX_WIDTH];
  logic signed [HGT_W-1:0] up_mem  [MAX_WIDTH];
  logic signed [HGT_W-1:0] ctr_rd, up_rd, ctr_wd;
  logic [CW-1:0]           ctr_wa, ctr_ra, up_ra;
  logic                    ctr_we;
  logic signed [HGT_W-1:0] centre_r, top_raw_r;
  logic signed [HGT_W-1:0] bottom;

  assign bottom = flush_r ? centre_r : bottom_r;
  assign ctr_we = (cmd.take && do_store) || cmd.wr;
  assign ctr_wa = cmd.wr ? c_r : col_r;
  assign ctr_wd = cmd.wr ? bottom : in_height;
  // second read fetches the right and left neighbours
  assign ctr_ra = cmd.rd_b ? c_r + CW'(1) : c_r;
  assign up_ra  = cmd.rd_b ? c_r - CW'(1) : c_r;

  always_ff @(posedge clk) begin
    if (ctr_we) ctr_mem[ctr_wa] <= ctr_wd;
    ctr_rd <= ctr_mem[ctr_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) up_mem[c_r] <= centre_r;
    up_rd <= up_mem[up_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_b) begin
      centre_r  <= ctr_rd;
      top_raw_r <= up_rd;
    end
  end

  // differences with edge clamping
  logic [CW:0]             c_p1;
  logic                    right_ok;
  logic signed [HGT_W-1:0] left, right, top;
  logic signed [HGT_W:0]   dx, dz;
  logic [HGT_W:0]          adx, adz;
  logic [24:0]             vprod;
  logic [DIM_W-1:0]        row_p1;

  assign c_p1     = {1'b0, c_r} + CW1'(1);
  assign right_ok = 15'(c_p1) < 15'(eff_w);
  assign left     = (c_r != '0) ? up_rd : centre_r;
  assign right    = right_ok ? ctr_rd : centre_r;
  assign top      = (row_r != '0) ? top_raw_r : centre_r;
  assign dx       = {left[HGT_W-1], left} - {right[HGT_W-1], right};
  assign dz       = {top[HGT_W-1], top} - {bottom[HGT_W-1], bottom};
  assign adx      = dx[HGT_W] ? ~dx + (HGT_W+1)'(1) : dx;
  assign adz      = dz[HGT_W] ? ~dz + (HGT_W+1)'(1) : dz;
  assign vprod    = 25'(row_r) * 25'(eff_w);
  assign row_p1   = {1'b0, row_r} + DIM_W'(1);

  logic [MAG_W-1:0]        mag_x_r, mag_z_r;
  logic                    neg_x_r, neg_z_r;
  logic [IDX_W-1:0]        vidx_r;
  logic signed [POS_W-1:0] posx_r, posz_r;
  logic                    quad_r;
  logic [1:0]              sq_cnt_r, comp_r;
  logic [SQ_W-1:0]         sq_r;
  logic [LEN2_W-1:0]       len2_r;
  logic [MAG_W-1:0]        sq_op, nu_mag;

  always_comb begin
    case (sq_cnt_r)
      2'd0:    sq_op = mag_x_r;
      2'd1:    sq_op = MAG_W'(sm_r);
      2'd2:    sq_op = mag_z_r;
      default: sq_op = '0;
    endcase
    case (comp_r)
      2'd0:    nu_mag = mag_x_r;
      2'd1:    nu_mag = MAG_W'(sm_r);
      default: nu_mag = mag_z_r;
    endcase
  end

  // squared length: one product per cycle, registered, then added to the sum in the next cycle
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mag_x_r  <= adx[MAG_W-1:0];
      mag_z_r  <= adz[MAG_W-1:0];
      neg_x_r  <= dx[HGT_W];
      neg_z_r  <= dz[HGT_W];
      vidx_r   <= IDX_W'(vprod + 25'(c_r));
      posx_r   <= POS_W'({c_r, 1'b0}) - POS_W'(eff_w);
      posz_r   <= POS_W'({row_r, 1'b0}) - POS_W'(eff_h);
      quad_r   <= (row_p1 < eff_h) && right_ok;
      sq_r     <= '0;
      len2_r   <= '0;
    end else if (cmd.sq) begin
      sq_r   <= sq_op * sq_op;
      len2_r <= len2_r + LEN2_W'(sq_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_cnt_r <= 2'd0;
    end else if (cmd.wr) begin
      sq_cnt_r <= 2'd0;
    end else if (cmd.sq) begin
      sq_cnt_r <= sq_cnt_r + 2'd1;
    end
  end

  // normaliser, one component at a time
  logic              nu_done;
  logic [NRMY_W-1:0] nu_mid;
  logic [NRM_W-1:0]  nu_mag_s;
  logic signed [NRM_W-1:0] nrm_x_r, nrm_z_r;
  logic [NRMY_W-1:0]       nrm_y_r;
  logic                    zero_len;

  hmvn_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.norm_go),
    .mag   (nu_mag),
    .den   (len2_r),
    .done  (nu_done),
    .mid   (nu_mid)
  );

  assign nu_mag_s = NRM_W'(nu_mid);
  assign zero_len = (len2_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comp_r <= 2'd0;
    end else if (cmd.wr) begin
      comp_r <= 2'd0;
    end else if (nu_done) begin
      comp_r <= comp_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (nu_done) begin
      case (comp_r)
        2'd0:    nrm_x_r <= zero_len ? '0 : (neg_x_r ? -nu_mag_s : nu_mag_s);
        2'd1:    nrm_y_r <= zero_len ? Q_ONE : nu_mid;
        default: nrm_z_r <= zero_len ? '0 : (neg_z_r ? -nu_mag_s : nu_mag_s);
      endcase
    end
  end

  // output register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_vertex_index  <= vidx_r;
      out_pos_x_half    <= posx_r;
      out_pos_z_half    <= posz_r;
      out_vertex_height <= centre_r;
      out_normal_x      <= nrm_x_r;
      out_normal_y      <= nrm_y_r;
      out_normal_z      <= nrm_z_r;
      out_quad_valid    <= quad_r;
      out_mesh_done     <= done_r;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    sts           = '0;
    sts.emit      = do_emit_s || do_flush;
    sts.sq_done   = (sq_cnt_r == 2'd3);
    sts.norm_done = nu_done;
    sts.comp_last = (comp_r == 2'd2);
    sts.out_busy  = out_valid_r && !out_ready;
  end

endmodule

FILE: sv/heightfield_mesh_vertex_normal.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightfield_mesh_vertex_normal
// Raster height samples in, mesh vertices with central-difference normals out.
// ----------------------------------------------------------------------------
// Items that give no vertex (first-row samples, ignored samples and early
// flushes) are taken without leaving the idle state. An item that gives a
// vertex passes through line-store reads and a write-back, squaring, then
// three passes of a shared normaliser, each a 31-step restoring division
// followed by a 16-step square root. The next item is taken while the
// finished vertex waits in the output register. After the last row, send
// one flush per column to drain it; mesh_done marks the final vertex, after
// which the next grid may start.
module heightfield_mesh_vertex_normal import hmvn_pkg::*; #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  hmvn_in_if.sink               in_ch,
  hmvn_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  hmvn_cmd_t cmd;
  hmvn_sts_t sts;

  hmvn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hmvn_dp #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_idx           (cfg_idx),
    .cfg_wdata         (cfg_wdata),
    .in_kind           (in_ch.kind),
    .in_height         (in_ch.height),
    .cmd               (cmd),
    .sts               (sts),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_vertex_index  (out_ch.vertex_index),
    .out_pos_x_half    (out_ch.pos_x_half),
    .out_pos_z_half    (out_ch.pos_z_half),
    .out_vertex_height (out_ch.vertex_height),
    .out_normal_x      (out_ch.normal_x),
    .out_normal_y      (out_ch.normal_y),
    .out_normal_z      (out_ch.normal_z),
    .out_quad_valid    (out_ch.quad_valid),
    .out_mesh_done     (out_ch.mesh_done)
  );

endmodule

FILE: bench/hmvn_vertex_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmvn_vertex_checker
// Watches the sample, vertex and register ports of the mesh vertex generator,
// predicts every vertex from accepted sample and flush beats and compares it field by
// field with the vertex beats that come out. Hands a mismatch count upward.
// ----------------------------------------------------------------------------
module hmvn_vertex_checker import hmvn_pkg::*; #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  hmvn_in_if                    in_mon,
  hmvn_out_if                   out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    errors,
  output int                    pending
);

  typedef struct {
    logic [IDX_W-1:0]        vertex_index;
    logic signed [POS_W-1:0] pos_x_half;
    logic signed [POS_W-1:0] pos_z_half;
    logic signed [HGT_W-1:0] vertex_height;
    logic signed [NRM_W-1:0] normal_x;
    logic [NRMY_W-1:0]       normal_y;
    logic signed [NRM_W-1:0] normal_z;
    logic                    quad_valid;
    logic                    mesh_done;
  } vertex_t;

  vertex_t vertex_q[$];

  logic [DIM_W-1:0]    gw, gh;
  logic [SMOOTH_W-1:0] smooth;
  int                  upper_row[MAX_WIDTH];
  int                  center_row[MAX_WIDTH];
  int unsigned         col_cnt, row_cnt;
  bit                  draining;

  assign pending = vertex_q.size();

  function automatic int unsigned width_eff();
    if (gw == 0) return 1;
    return (gw > MAX_WIDTH) ? MAX_WIDTH : gw;
  endfunction

  function automatic int unsigned height_eff();
    if (gh == 0) return 1;
    return (gh > ROW_CAP) ? ROW_CAP : gh;
  endfunction

  // rounded |v| * 2^14 / sqrt(len2) with the sign of v, by search on the half-step boundaries
  function automatic int scale_unit(longint v, longint unsigned len2);
    longint unsigned mag, rhs, t;
    int unsigned lo, hi, mid;
    mag = (v < 0) ? -v : v;
    rhs = mag * mag * (64'd1 << 30);
    lo = 0;
    hi = Q_ONE;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      t = 2 * longint'(mid) - 1;
      if (t * t * len2 <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return (v < 0) ? -int'(lo) : int'(lo);
  endfunction

  function automatic vertex_t make_vertex(int unsigned row, int unsigned c, int bottom);
    vertex_t vx;
    int unsigned w, h;
    int centre, left, right, top, ux, uy, uz;
    longint nx, ny, nz;
    longint unsigned len2;
    w = width_eff();
    h = height_eff();
    centre = center_row[c];
    left   = (c > 0) ? upper_row[c-1] : centre;
    right  = (c + 1 < w && c + 1 < MAX_WIDTH) ? center_row[c+1] : centre;
    top    = (row > 0) ? upper_row[c] : centre;
    nx = longint'(left) - right;
    ny = longint'(smooth);
    nz = longint'(top) - bottom;
    len2 = nx * nx + ny * ny + nz * nz;
    ux = 0;
    uy = Q_ONE;
    uz = 0;
    if (len2 != 0) begin
      ux = scale_unit(nx, len2);
      uy = scale_unit(ny, len2);
      uz = scale_unit(nz, len2);
    end
    upper_row[c]  = centre;
    center_row[c] = bottom;
    vx.vertex_index  = row * w + c;
    vx.pos_x_half    = int'(2 * c) - int'(w);
    vx.pos_z_half    = int'(2 * row) - int'(h);
    vx.vertex_height = centre;
    vx.normal_x      = ux;
    vx.normal_y      = uy;
    vx.normal_z      = uz;
    vx.quad_valid    = (row + 1 < h) && (c + 1 < w);
    vx.mesh_done     = 1'b0;
    return vx;
  endfunction

  task automatic predict_beat(logic kind, logic signed [HGT_W-1:0] hgt);
    int unsigned w, h, c;
    bit last_col;
    vertex_t vx;
    w = width_eff();
    h = height_eff();
    c = (col_cnt >= MAX_WIDTH) ? 0 : col_cnt;
    last_col = (c + 1 >= w);
    if (kind == KIND_SAMPLE) begin
      if (draining || row_cnt >= h) return;
      if (row_cnt == 0) center_row[c] = hgt;
      else begin
        vx = make_vertex(row_cnt - 1, c, hgt);
        vertex_q.insert(vertex_q.size(), vx);
      end
      if (last_col) begin
        col_cnt = 0;
        row_cnt++;
      end else col_cnt = c + 1;
    end else begin
      if (row_cnt < h || row_cnt == 0) return;
      draining = 1;
      vx = make_vertex(row_cnt - 1, c, center_row[c]);
      if (last_col) begin
        vx.mesh_done = 1'b1;
        col_cnt = 0;
        row_cnt = 0;
        draining = 0;
      end else col_cnt = c + 1;
      vertex_q.insert(vertex_q.size(), vx);
    end
  endtask

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    vertex_t vx;
    if (!rst_n) begin
      gw = GW_RESET;
      gh = GH_RESET;
      smooth = SMOOTH_RESET;
      col_cnt = 0;
      row_cnt = 0;
      draining = 0;
      errors = 0;
      vertex_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_GRID_WIDTH:       gw = cfg_wdata[DIM_W-1:0];
          CFG_GRID_HEIGHT:      gh = cfg_wdata[DIM_W-1:0];
          CFG_NORMAL_SMOOTHING: smooth = cfg_wdata[SMOOTH_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) predict_beat(in_mon.kind, in_mon.height);
      if (out_mon.valid && out_mon.ready) begin
        if (vertex_q.size() == 0) begin
          $error("vertex beat with index %0d and nothing expected", out_mon.vertex_index);
          errors++;
        end else begin
          vx = vertex_q.pop_front();
          check_field("vertex_index", vx.vertex_index, out_mon.vertex_index);
          check_field("pos_x_half", vx.pos_x_half, out_mon.pos_x_half);
          check_field("pos_z_half", vx.pos_z_half, out_mon.pos_z_half);
          check_field("vertex_height", vx.vertex_height, out_mon.vertex_height);
          check_field("normal_x", vx.normal_x, out_mon.normal_x);
          check_field("normal_y", vx.normal_y, out_mon.normal_y);
          check_field("normal_z", vx.normal_z, out_mon.normal_z);
          check_field("quad_valid", vx.quad_valid, out_mon.quad_valid);
          check_field("mesh_done", vx.mesh_done, out_mon.mesh_done);
        end
      end
    end
  end

endmodule

FILE: bench/heightfield_mesh_vertex_normal_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightfield_mesh_vertex_normal_tb
// Streams whole height grids (samples, then one flush per column) through the
// vertex generator under changing grid sizes and smoothing, with random gaps
// on both channels and stray samples and flushes mixed in.
// ----------------------------------------------------------------------------
module heightfield_mesh_vertex_normal_tb;
  import hmvn_pkg::*;

  localparam int LIMIT = 3000000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    errors, pending;
  int                    idle_in, idle_out;
  int                    beats_sent;
  int                    cycles = 0;

  hmvn_in_if  in_ch();
  hmvn_out_if out_ch();

  heightfield_mesh_vertex_normal DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  hmvn_vertex_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= idle_out);
  end

  function automatic logic [HGT_W-1:0] pick_height();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_beat(logic kind, logic [HGT_W-1:0] hgt);
    while ($urandom_range(99) < idle_in) begin
      in_ch.valid <= 1'b0;
      in_ch.kind <= 1'($urandom);
      in_ch.height <= 16'($urandom);
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.height <= hgt;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
    beats_sent++;
  endtask

  task automatic drain_vertices();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // one full grid; w and h are the effective sizes, noise adds stray beats
  task automatic run_grid(int w, int h, bit noise, int hold_at);
    int n;
    for (n = 0; n < w * h; n++) begin
      if (noise && $urandom_range(15) == 0) send_beat(KIND_FLUSH, pick_height());
      if (n == hold_at) drain_vertices();
      send_beat(KIND_SAMPLE, pick_height());
    end
    if (noise && $urandom_range(1)) send_beat(KIND_SAMPLE, pick_height());
    for (n = 0; n < w; n++) begin
      send_beat(KIND_FLUSH, pick_height());
      if (noise && $urandom_range(9) == 0) send_beat(KIND_SAMPLE, pick_height());
    end
  endtask

  task automatic set_grid(int w, int h, int s);
    drain_vertices();
    write_reg(CFG_GRID_WIDTH, 15'(w));
    write_reg(CFG_GRID_HEIGHT, 15'(h));
    write_reg(CFG_NORMAL_SMOOTHING, 15'(s));
  endtask

  initial begin
    int w, h;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_SAMPLE;
    in_ch.height = '0;
    beats_sent = 0;
    idle_in = 24;
    idle_out = 82;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset sizes: a single point, every neighbour clamped
    send_beat(KIND_FLUSH, 16'h0);
    run_grid(1, 1, 0, -1);
    // zero sizes act as one, upper data bits are dropped
    set_grid(15'h6000, 15'h6000, 1);
    run_grid(1, 1, 0, -1);
    set_grid(3, 3, 1);
    run_grid(3, 3, 1, -1);
    set_grid(15'h6002, 15'h6004, 32767);
    write_reg(3, 15'h7fff);
    run_grid(2, 4, 0, -1);

    while (beats_sent < 1900) begin
      if (beats_sent > 1300) begin
        idle_in = 0;
        idle_out = 0;
      end else if (beats_sent > 650) begin
        idle_in = 82;
        idle_out = 24;
      end
      if ($urandom_range(19) == 0) begin
        w = $urandom_range(120, 60);
        h = 2;
      end else begin
        w = $urandom_range(12, 1);
        h = $urandom_range(8, 1);
      end
      set_grid(w, h, ($urandom_range(3) == 0) ? $urandom_range(32767, 1)
                                              : $urandom_range(2048, 1));
      run_grid(w, h, 1, ($urandom_range(9) == 0) ? $urandom_range(w * h - 1) : -1);
    end

    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

FILE: files.f
sv/hmvn_pkg.sv
sv/hmvn_if.sv
sv/hmvn_norm.sv
sv/hmvn_ctrl.sv
sv/hmvn_dp.sv
sv/heightfield_mesh_vertex_normal.sv
bench/hmvn_vertex_checker.sv
bench/heightfield_mesh_vertex_normal_tb.sv
